// ----- hw/rtl/dac_sweep_sequencer_assert.svh -----
// Assertion macros for the checker file of the DAC sweep sequencer.
`ifndef DAC_SWEEP_SEQUENCER_ASSERT_SVH
`define DAC_SWEEP_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DSS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/dss_pkg.sv -----
package dss_pkg;

	localparam int LEVEL_W = 12;
	localparam int SLOT_W  = 10;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 12;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_START_LEVEL       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOP_LEVEL         = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE         = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSE_THRESHOLD = 2'd3;

	// Register values after reset.
	localparam logic [LEVEL_W-1:0] START_LEVEL_RST       = 12'd1000;
	localparam logic [LEVEL_W-1:0] TOP_LEVEL_RST         = 12'd4095;
	localparam logic [LEVEL_W-1:0] STEP_SIZE_RST         = 12'd5;
	localparam logic [LEVEL_W-1:0] REVERSE_THRESHOLD_RST = 12'd3000;

	// Input codes.
	localparam logic MODE_SAMPLE = 1'b0;
	localparam logic MODE_START  = 1'b1;

	typedef struct packed {
		logic               mode;
		logic [LEVEL_W-1:0] adc_sample;
	} in_item_t;

	typedef struct packed {
		logic               dac_write;
		logic [LEVEL_W-1:0] dac_level;
		logic               record_valid;
		logic [SLOT_W-1:0]  record_slot;
		logic [LEVEL_W-1:0] record_level;
		logic [LEVEL_W-1:0] record_sample;
		logic               sweep_done;
		logic [SLOT_W-1:0]  sweep_length;
	} out_item_t;

endpackage

// ----- hw/rtl/dss_stream_if.sv -----
interface dss_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/dac_sweep_sequencer.sv -----
// DAC sweep sequencer.
// A result is registered and appears in the cycle after its input transaction is accepted.
// Throughput: one transaction per cycle while the output is not stalled; the single output register lets a new
// input be taken in the same cycle that the held result is taken downstream.
// Reset (arst_n low, asynchronous): idle, level 0, slot 0, sweeping up, registers at defaults.
module dac_sweep_sequencer
	import dss_pkg::*;
#(
	parameter int SLOT_LIMIT = 850
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	dss_stream_if.sink            in_stream,
	dss_stream_if.source          out_stream
);

	localparam logic [SLOT_W:0] LIMIT_C = (SLOT_W+1)'(SLOT_LIMIT);
	localparam int CALC_W = LEVEL_W + 2;

	logic [LEVEL_W-1:0] start_level_q, top_level_q, step_size_q, reverse_threshold_q;
	logic [LEVEL_W-1:0] level_q;
	logic               going_down_q;
	logic [SLOT_W-1:0]  slot_q;
	logic               armed_q;
	logic               out_valid_q;
	out_item_t          out_payload_q;

	logic                     accept;
	in_item_t                 item;
	out_item_t                result;
	logic                     gd;
	logic [SLOT_W:0]          pos_sum;
	logic [SLOT_W:0]          next_pos;
	logic                     done;
	logic signed [CALC_W-1:0] nl_raw;
	logic signed [CALC_W-1:0] nl_lo;
	logic [LEVEL_W-1:0]       nl;
	logic [LEVEL_W-1:0]       level_d;
	logic                     going_down_d;
	logic [SLOT_W-1:0]        slot_d;
	logic                     armed_d;

	// Input is taken whenever the output register is empty or being drained.
	assign in_stream.ready = !out_valid_q || out_stream.ready;
	assign accept = in_stream.valid && in_stream.ready;
	assign item = in_stream.payload;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_level_q       <= START_LEVEL_RST;
			top_level_q         <= TOP_LEVEL_RST;
			step_size_q         <= STEP_SIZE_RST;
			reverse_threshold_q <= REVERSE_THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_LEVEL:       start_level_q       <= cfg_data;
				REG_TOP_LEVEL:         top_level_q         <= cfg_data;
				REG_STEP_SIZE:         step_size_q         <= cfg_data;
				REG_REVERSE_THRESHOLD: reverse_threshold_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Direction, slot advance and end-of-sweep detection.
	always_comb begin
		gd = going_down_q || (item.adc_sample < reverse_threshold_q) ||
			(level_q >= top_level_q);
		pos_sum = {1'b0, slot_q} + (SLOT_W+1)'(2);
		next_pos = (pos_sum > LIMIT_C) ? LIMIT_C : pos_sum;
		done = (gd && (level_q <= start_level_q)) || (next_pos == LIMIT_C);
	end

	// Next level: step or restart, then clamp to start..top.
	always_comb begin
		if (done) begin
			nl_raw = signed'({2'b00, start_level_q});
		end else if (gd) begin
			nl_raw = signed'({2'b00, level_q}) - signed'({2'b00, step_size_q});
		end else begin
			nl_raw = signed'({2'b00, level_q}) + signed'({2'b00, step_size_q});
		end
		nl_lo = (nl_raw < signed'({2'b00, start_level_q})) ?
			signed'({2'b00, start_level_q}) : nl_raw;
		nl = (nl_lo > signed'({2'b00, top_level_q})) ? top_level_q : nl_lo[LEVEL_W-1:0];
	end

	// Result and next state for one transaction.
	always_comb begin
		result       = '0;
		level_d      = level_q;
		going_down_d = going_down_q;
		slot_d       = slot_q;
		armed_d      = armed_q;
		if (item.mode == MODE_START) begin
			armed_d          = 1'b1;
			result.dac_write = 1'b1;
			result.dac_level = level_q;
		end else if (armed_q) begin
			result.dac_write     = 1'b1;
			result.record_valid  = 1'b1;
			result.record_slot   = slot_q;
			result.record_level  = level_q;
			result.record_sample = item.adc_sample;
			level_d              = nl;
			if (done) begin
				result.sweep_done   = 1'b1;
				result.sweep_length = next_pos[SLOT_W-1:0] - SLOT_W'(2);
				armed_d             = 1'b0;
				going_down_d        = 1'b0;
				slot_d              = '0;
			end else begin
				result.dac_level = level_q;
				going_down_d     = gd;
				slot_d           = next_pos[SLOT_W-1:0];
			end
		end
	end

	// Sweep state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q      <= '0;
			going_down_q <= 1'b0;
			slot_q       <= '0;
			armed_q      <= 1'b0;
		end else if (accept) begin
			level_q      <= level_d;
			going_down_q <= going_down_d;
			slot_q       <= slot_d;
			armed_q      <= armed_d;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_stream.ready) begin
			out_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_payload_q <= result;
		end
	end

	assign out_stream.valid   = out_valid_q;
	assign out_stream.payload = out_payload_q;

endmodule

// ----- hw/rtl/dss_checker.sv -----
`include "dac_sweep_sequencer_assert.svh"

module dss_checker
	import dss_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_payload
);

	// A stalled result must hold.
	`DSS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_payload), "stalled result changed")

	// Every accepted transaction shows a result in the next cycle.
	`DSS_ASSERT_NEXT(a_in_to_out, clk, arst_n, in_valid && in_ready, out_valid, "accepted input produced no result")

	// The end of a sweep always records a pair and writes 0 to the DAC.
	`DSS_ASSERT_NOW(a_done_shape, clk, arst_n, out_valid && out_payload.sweep_done, out_payload.record_valid && out_payload.dac_write && (out_payload.dac_level == '0), "sweep end result malformed")

	// Recorded pairs always sit at even slots; an unrecorded result carries no record.
	`DSS_ASSERT_NOW(a_even_slot, clk, arst_n, out_valid && out_payload.record_valid, !out_payload.record_slot[0], "record slot is odd")

	`DSS_ASSERT_NOW(a_no_record, clk, arst_n, out_valid && !out_payload.record_valid, !out_payload.sweep_done && (out_payload.record_slot == '0) && (out_payload.record_sample == '0), "idle result carries record data")

endmodule

bind dac_sweep_sequencer dss_checker u_dss_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_stream.valid),
	.in_ready    (in_stream.ready),
	.out_valid   (out_stream.valid),
	.out_ready   (out_stream.ready),
	.out_payload (out_stream.payload)
);
